[design/jpsh_pkg.sv]
// Shared types, constants and helper functions for the jittered PC sample histogram.
// Used by every design module; depends on nothing.
`default_nettype none

package jpsh_pkg;

  localparam int TableEntries = 256;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int FillW        = $clog2(TableEntries + 1);

  localparam int SlotW        = 8;
  localparam int TableFillW   = 9;
  localparam int SiteW        = 16;
  localparam int CountW       = 32;
  localparam int IntervalW    = 15;
  localparam int LfsrW        = 16;
  localparam int CfgDataW     = 16;
  localparam int DivSteps     = LfsrW;
  localparam int DivCntW      = $clog2(DivSteps);

  localparam int FifoDepth    = 4;
  localparam int FifoPtrW     = $clog2(FifoDepth);

  localparam logic [LfsrW-1:0]     LfsrTaps      = 16'hB400;
  localparam logic [LfsrW-1:0]     SeedFallback  = 16'hACE1;
  localparam logic [IntervalW-1:0] IntervalReset = 15'd1000;
  localparam logic [LfsrW-1:0]     SeedReset     = 16'd44257;
  localparam logic [CountW-1:0]    CountMax      = '1;

  typedef enum logic {
    CFG_INTERVAL = 1'b0,
    CFG_SEED     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_NEW  = 2'd1,
    KIND_DROP = 2'd2,
    KIND_READ = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_START,
    BK_SEARCH,
    BK_READ
  } bk_state_e;

  // request from the front to the back
  typedef struct packed {
    logic             readout;
    logic [SiteW-1:0] blk;
    logic [SiteW-1:0] off;
    logic [SlotW-1:0] ridx;
  } req_t;

  typedef struct packed {
    kind_e                 kind;
    logic [SlotW-1:0]      slot;
    logic                  valid;
    logic [SiteW-1:0]      blk;
    logic [SiteW-1:0]      off;
    logic [CountW-1:0]     count;
    logic [TableFillW-1:0] fill;
  } res_t;

  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] s);
    logic [LfsrW-1:0] r;
    r = s >> 1;
    if (s[0]) begin
      r = r ^ LfsrTaps;
    end
    return r;
  endfunction

  function automatic logic [LfsrW-1:0] seed_value(input logic [LfsrW-1:0] s);
    return (s == '0) ? SeedFallback : s;
  endfunction

endpackage

`default_nettype wire

[design/jpsh_fifo.sv]
// Short request queue between the front and the back.
// Depends on jpsh_pkg.
`default_nettype none

module jpsh_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jpsh_pkg::req_t data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output jpsh_pkg::req_t     data_o,
  output logic               empty_o
);

  jpsh_pkg::req_t mem_q [jpsh_pkg::FifoDepth];
  logic [jpsh_pkg::FifoPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [jpsh_pkg::FifoPtrW:0]   level_q, level_d;
  logic do_push, do_pop;

  assign full_o  = (level_q == (jpsh_pkg::FifoPtrW+1)'(jpsh_pkg::FifoDepth));
  assign empty_o = (level_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    level_d  = level_q;
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (!do_push && do_pop) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/jpsh_front.sv]
// Front end: sample countdown, jitter LFSR, reload remainder unit and configuration.
// Classifies ticks and forwards samples and readouts as requests. Depends on jpsh_pkg.
`default_nettype none

module jpsh_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_idx_i,
  input  wire logic [jpsh_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            push_i,
  input  wire logic                            mode_i,
  input  wire logic [jpsh_pkg::SiteW-1:0]      block_id_i,
  input  wire logic [jpsh_pkg::SiteW-1:0]      instr_offset_i,
  input  wire logic [jpsh_pkg::SlotW-1:0]      read_index_i,
  output logic                                 full_o,
  input  wire logic                            req_full_i,
  output logic                                 req_push_o,
  output jpsh_pkg::req_t                       req_o
);

  localparam int LfsrW = jpsh_pkg::LfsrW;

  logic [jpsh_pkg::IntervalW-1:0] interval_q, interval_d;
  logic [LfsrW-1:0] lfsr_q, lfsr_d;
  logic [LfsrW-1:0] countdown_q, countdown_d;
  logic restart_q, restart_d;
  logic busy_q, busy_d;
  logic [jpsh_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [LfsrW-1:0] num_q, num_d, rem_q, rem_d, mod_q, mod_d, reload_q, reload_d;

  logic accept, sample_due, rem_ready;
  logic [LfsrW:0] trial, diff;
  logic [LfsrW-1:0] step_rem, new_mod;

  assign sample_due = (countdown_q <= LfsrW'(1));
  assign rem_ready  = ~restart_q & ~busy_q;
  assign full_o     = req_full_i | (sample_due & ~rem_ready);
  assign accept     = push_i & ~full_o;
  assign req_push_o = accept & (mode_i | sample_due);

  assign req_o.readout = mode_i;
  assign req_o.blk     = block_id_i;
  assign req_o.off     = instr_offset_i;
  assign req_o.ridx    = read_index_i;

  // one restoring step of lfsr mod (2 * interval)
  assign trial    = {rem_q, num_q[LfsrW-1]};
  assign diff     = trial - {1'b0, mod_q};
  assign step_rem = (trial >= {1'b0, mod_q}) ? diff[LfsrW-1:0] : trial[LfsrW-1:0];
  assign new_mod  = {interval_q, 1'b0};

  always_comb begin
    interval_d  = interval_q;
    lfsr_d      = lfsr_q;
    countdown_d = countdown_q;
    restart_d   = restart_q;
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    rem_d       = rem_q;
    mod_d       = mod_q;
    reload_d    = reload_q;

    if (restart_q) begin
      restart_d = 1'b0;
      mod_d     = new_mod;
      if (new_mod == '0) begin
        reload_d = LfsrW'(1);
        busy_d   = 1'b0;
      end else begin
        num_d  = jpsh_pkg::lfsr_next(lfsr_q);
        rem_d  = '0;
        cnt_d  = jpsh_pkg::DivCntW'(jpsh_pkg::DivSteps - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = step_rem;
      num_d = num_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d   = 1'b0;
        reload_d = step_rem + LfsrW'(1);
      end
    end

    if (cfg_we_i) begin
      unique case (jpsh_pkg::cfg_idx_e'(cfg_idx_i))
        jpsh_pkg::CFG_INTERVAL: begin
          interval_d = cfg_data_i[jpsh_pkg::IntervalW-1:0];
          restart_d  = 1'b1;
        end
        jpsh_pkg::CFG_SEED: begin
          lfsr_d    = jpsh_pkg::seed_value(cfg_data_i);
          restart_d = 1'b1;
        end
        default: ;
      endcase
    end

    if (accept && !mode_i) begin
      if (sample_due) begin
        lfsr_d      = jpsh_pkg::lfsr_next(lfsr_q);
        countdown_d = reload_q;
        restart_d   = 1'b1;
      end else begin
        countdown_d = countdown_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= jpsh_pkg::IntervalReset;
      lfsr_q      <= jpsh_pkg::seed_value(jpsh_pkg::SeedReset);
      countdown_q <= LfsrW'(jpsh_pkg::IntervalReset);
      restart_q   <= 1'b1;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      interval_q  <= interval_d;
      lfsr_q      <= lfsr_d;
      countdown_q <= countdown_d;
      restart_q   <= restart_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    mod_q    <= mod_d;
    reload_q <= reload_d;
  end

endmodule

`default_nettype wire

[design/jpsh_back.sv]
// Back end: site table memories, linear search, count update, append and readout.
// Holds the result register. Depends on jpsh_pkg.
`default_nettype none

module jpsh_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_empty_i,
  input  wire jpsh_pkg::req_t req_i,
  output logic                req_pop_o,
  output logic                res_valid_o,
  output jpsh_pkg::res_t      res_o,
  input  wire logic           res_pop_i
);

  localparam int IdxW  = jpsh_pkg::IdxW;
  localparam int FillW = jpsh_pkg::FillW;
  localparam int KeyW  = 2 * jpsh_pkg::SiteW;

  logic [KeyW-1:0]             key_mem [jpsh_pkg::TableEntries];
  logic [jpsh_pkg::CountW-1:0] cnt_mem [jpsh_pkg::TableEntries];
  logic [KeyW-1:0]             key_rd_q;
  logic [jpsh_pkg::CountW-1:0] cnt_rd_q;

  jpsh_pkg::bk_state_e state_q, state_d;
  jpsh_pkg::req_t      cur_q, cur_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic                res_valid_q, res_valid_d;
  jpsh_pkg::res_t      res_q, res_d;

  logic            rd_en, key_we, cnt_we, res_load, miss_now;
  logic [IdxW-1:0] rd_addr, wr_addr;
  logic [KeyW-1:0] cur_key;
  logic [jpsh_pkg::CountW-1:0] cnt_wdata, hit_cnt;
  logic start, rd_in_range, is_match, has_next, has_room;

  assign cur_key     = {cur_q.blk, cur_q.off};
  assign start       = ~req_empty_i & ~res_valid_q;
  assign rd_in_range = (32'(cur_q.ridx) < 32'(fill_q));
  assign is_match    = (key_rd_q == cur_key);
  assign has_next    = (32'(idx_q) + 32'd1 < 32'(fill_q));
  assign has_room    = (32'(fill_q) < 32'(jpsh_pkg::TableEntries));
  assign hit_cnt     = (cnt_rd_q == jpsh_pkg::CountMax) ? cnt_rd_q : cnt_rd_q + 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jpsh_pkg::BK_IDLE: begin
        if (start) begin
          state_d = jpsh_pkg::BK_START;
        end
      end
      jpsh_pkg::BK_START: begin
        if (cur_q.readout) begin
          state_d = rd_in_range ? jpsh_pkg::BK_READ : jpsh_pkg::BK_IDLE;
        end else begin
          state_d = (fill_q == '0) ? jpsh_pkg::BK_IDLE : jpsh_pkg::BK_SEARCH;
        end
      end
      jpsh_pkg::BK_SEARCH: begin
        if (is_match || !has_next) begin
          state_d = jpsh_pkg::BK_IDLE;
        end
      end
      jpsh_pkg::BK_READ: state_d = jpsh_pkg::BK_IDLE;
      default: state_d = jpsh_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    req_pop_o = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_q;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    wr_addr   = idx_q;
    cnt_wdata = hit_cnt;
    res_load  = 1'b0;
    miss_now  = 1'b0;
    cur_d     = cur_q;
    idx_d     = idx_q;
    fill_d    = fill_q;
    res_d     = res_q;

    unique case (state_q)
      jpsh_pkg::BK_IDLE: begin
        if (start) begin
          req_pop_o = 1'b1;
          cur_d     = req_i;
        end
      end
      jpsh_pkg::BK_START: begin
        if (cur_q.readout) begin
          if (rd_in_range) begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(cur_q.ridx);
          end else begin
            res_load    = 1'b1;
            res_d.kind  = jpsh_pkg::KIND_READ;
            res_d.slot  = cur_q.ridx;
            res_d.valid = 1'b0;
            res_d.blk   = '0;
            res_d.off   = '0;
            res_d.count = '0;
            res_d.fill  = jpsh_pkg::TableFillW'(fill_q);
          end
        end else if (fill_q == '0) begin
          miss_now = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          idx_d   = '0;
        end
      end
      jpsh_pkg::BK_SEARCH: begin
        if (is_match) begin
          cnt_we      = 1'b1;
          res_load    = 1'b1;
          res_d.kind  = jpsh_pkg::KIND_HIT;
          res_d.slot  = jpsh_pkg::SlotW'(idx_q);
          res_d.valid = 1'b1;
          res_d.blk   = cur_q.blk;
          res_d.off   = cur_q.off;
          res_d.count = hit_cnt;
          res_d.fill  = jpsh_pkg::TableFillW'(fill_q);
        end else if (has_next) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + 1'b1;
          idx_d   = idx_q + 1'b1;
        end else begin
          miss_now = 1'b1;
        end
      end
      jpsh_pkg::BK_READ: begin
        res_load    = 1'b1;
        res_d.kind  = jpsh_pkg::KIND_READ;
        res_d.slot  = cur_q.ridx;
        res_d.valid = 1'b1;
        res_d.blk   = key_rd_q[KeyW-1 -: jpsh_pkg::SiteW];
        res_d.off   = key_rd_q[jpsh_pkg::SiteW-1:0];
        res_d.count = cnt_rd_q;
        res_d.fill  = jpsh_pkg::TableFillW'(fill_q);
      end
      default: ;
    endcase

    if (miss_now) begin
      res_load  = 1'b1;
      res_d.blk = cur_q.blk;
      res_d.off = cur_q.off;
      if (has_room) begin
        key_we      = 1'b1;
        cnt_we      = 1'b1;
        wr_addr     = IdxW'(fill_q);
        cnt_wdata   = jpsh_pkg::CountW'(1);
        fill_d      = fill_q + 1'b1;
        res_d.kind  = jpsh_pkg::KIND_NEW;
        res_d.slot  = jpsh_pkg::SlotW'(fill_q);
        res_d.valid = 1'b1;
        res_d.count = jpsh_pkg::CountW'(1);
        res_d.fill  = jpsh_pkg::TableFillW'(fill_d);
      end else begin
        res_d.kind  = jpsh_pkg::KIND_DROP;
        res_d.slot  = '0;
        res_d.valid = 1'b0;
        res_d.count = '0;
        res_d.fill  = jpsh_pkg::TableFillW'(fill_q);
      end
    end

    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (res_pop_i) begin
      res_valid_d = 1'b0;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jpsh_pkg::BK_IDLE;
      fill_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    idx_q <= idx_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= cur_key;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[wr_addr] <= cnt_wdata;
    end
    if (rd_en) begin
      cnt_rd_q <= cnt_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/jittered_pc_sample_histogram.sv]
// Jittered PC sample histogram: instruction ticks and readout requests in, one result per
// sample or readout out. Instruction ticks in through push/full, results out through
// empty/pop, config through cfg_we_i/cfg_idx_i/cfg_data_i (0 interval, 1 seed).
// A tick is taken each cycle while full is low; it only decrements the countdown
// unless the countdown has run out, in which case the tick becomes a sample request.
// The next reload value (1 + lfsr mod 2*interval) is precomputed by a 16-step
// remainder unit, one bit a cycle; a tick that finds the countdown expired while that
// unit is still busy (after the previous sample or a config write) waits with full high.
// Samples and readouts pass a 4-deep request queue to the back end, which walks the site
// table one entry per cycle: a sample compares at most 256 entries and a readout reads
// at most one before its result shows with empty low.
// While a result is not popped, the back end holds and the queue fills; the front keeps
// taking ticks that produce no result until the queue is full.
// Reset: countdown and interval 1000, seed 44257, table empty; no clearing pass.
// Depends on jpsh_pkg, jpsh_front, jpsh_fifo, jpsh_back.
`default_nettype none

module jittered_pc_sample_histogram (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_idx_i,
  input  wire logic [jpsh_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic                              mode_i,
  input  wire logic [jpsh_pkg::SiteW-1:0]        block_id_i,
  input  wire logic [jpsh_pkg::SiteW-1:0]        instr_offset_i,
  input  wire logic [jpsh_pkg::SlotW-1:0]        read_index_i,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [1:0]                             result_kind_o,
  output logic [jpsh_pkg::SlotW-1:0]             slot_index_o,
  output logic                                   entry_valid_o,
  output logic [jpsh_pkg::SiteW-1:0]             site_block_o,
  output logic [jpsh_pkg::SiteW-1:0]             site_offset_o,
  output logic [jpsh_pkg::CountW-1:0]            site_count_o,
  output logic [jpsh_pkg::TableFillW-1:0]        table_fill_o
);

  jpsh_pkg::req_t fe_req, q_req;
  jpsh_pkg::res_t res;
  logic fe_push, q_full, q_empty, q_pop, res_valid;

  jpsh_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .push_i         (push),
    .mode_i,
    .block_id_i,
    .instr_offset_i,
    .read_index_i,
    .full_o         (full),
    .req_full_i     (q_full),
    .req_push_o     (fe_push),
    .req_o          (fe_req)
  );

  jpsh_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (fe_push),
    .data_i  (fe_req),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_req),
    .empty_o (q_empty)
  );

  jpsh_back u_back (
    .clk_i,
    .rst_ni,
    .req_empty_i (q_empty),
    .req_i       (q_req),
    .req_pop_o   (q_pop),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_pop_i   (pop)
  );

  assign empty         = ~res_valid;
  assign result_kind_o = res.kind;
  assign slot_index_o  = res.slot;
  assign entry_valid_o = res.valid;
  assign site_block_o  = res.blk;
  assign site_offset_o = res.off;
  assign site_count_o  = res.count;
  assign table_fill_o  = res.fill;

endmodule

`default_nettype wire
